FILE: rtl/core/piecewise_cubic_evaluator_core_macros.svh
// Assertion macros for the piecewise cubic evaluator core.
// Included by the top level; no other dependencies.
`ifndef PIECEWISE_CUBIC_EVALUATOR_CORE_MACROS_SVH
`define PIECEWISE_CUBIC_EVALUATOR_CORE_MACROS_SVH

`ifndef SYNTH

// Concurrent assertion, disabled while reset is asserted.
`define PCE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define PCE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PCE_ASSERT(lbl, clk, rst_n, prop, msg)
`define PCE_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

FILE: rtl/core/pce_pkg.sv
// Shared types and constants of the piecewise cubic evaluator core.
// No dependencies.
package pce_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned IdxW  = 5;
  localparam int unsigned CfgW  = 6;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  // One segment entry as held in the segment memory.
  typedef struct packed {
    logic [DataW-1:0] knot;
    logic [DataW-1:0] cubic;
    logic [DataW-1:0] square;
    logic [DataW-1:0] linear;
    logic [DataW-1:0] constant;
  } seg_t;

  // Control of the shared multiply and accumulate unit.
  typedef struct packed {
    logic load;
    logic mul;
    logic acc;
  } mac_ctrl_t;

endpackage

FILE: rtl/core/pce_seg_mem.sv
// Segment memory: one write port and one registered read port.
// Depends on pce_pkg for the entry type.
module pce_seg_mem #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  pce_pkg::seg_t wdata_i,
  input  logic [AW-1:0] raddr_i,
  output pce_pkg::seg_t rdata_o
);

  pce_pkg::seg_t mem_q [DEPTH];
  pce_pkg::seg_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/pce_mac.sv
// Shared multiply and accumulate unit for the Horner stages.
// Depends on pce_pkg for the control struct and data width.
module pce_mac #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                               clk_i,
  input  pce_pkg::mac_ctrl_t                 ctrl_i,
  input  logic        [pce_pkg::DataW-1:0]   diff_i,
  input  logic signed [pce_pkg::DataW-1:0]   init_i,
  input  logic signed [pce_pkg::DataW-1:0]   coef_i,
  output logic signed [pce_pkg::DataW-1:0]   acc_o,
  output logic                               clip_o
);

  localparam int unsigned W = pce_pkg::DataW;

  logic signed [W-1:0]   acc_q;
  logic                  clip_q;
  logic signed [2*W-1:0] prod_q;
  logic signed [W:0]     diff_s;
  logic signed [2*W:0]   prod_full;
  logic signed [2*W-1:0] shifted;
  logic signed [2*W:0]   sum;
  logic                  no_ovf;
  logic signed [W-1:0]   sat_val;

  // The difference is unsigned, so it enters the multiplier with a zero sign bit.
  assign diff_s    = $signed({1'b0, diff_i});
  assign prod_full = diff_s * acc_q;

  // An arithmetic shift floors toward minus infinity.
  assign shifted = prod_q >>> FRAC_BITS;
  assign sum     = $signed({shifted[2*W-1], shifted}) + $signed({{(W+1){coef_i[W-1]}}, coef_i});
  assign no_ovf  = (&sum[2*W:W-1]) | ~(|sum[2*W:W-1]);

  always_comb begin
    if (no_ovf) begin
      sat_val = sum[W-1:0];
    end else if (sum[2*W]) begin
      sat_val = {1'b1, {(W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul) begin
      prod_q <= prod_full[2*W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      acc_q  <= init_i;
      clip_q <= 1'b0;
    end else if (ctrl_i.acc) begin
      acc_q  <= sat_val;
      clip_q <= clip_q | ~no_ovf;
    end
  end

  assign acc_o  = acc_q;
  assign clip_o = clip_q;

endmodule

FILE: rtl/core/piecewise_cubic_evaluator_core.sv
// Piecewise cubic evaluator: segment memory, knot search and Horner evaluation.
// Depends on pce_pkg, pce_seg_mem, pce_mac and the core macros header.
//
// A write item stores one segment entry and does not stall the input. The
// knot search reads one entry a cycle through the single read port of the
// segment memory, over segments_in_use clipped to MAX_SEGMENTS entries. For a
// query inside the knot span the chosen entry is then fetched, and the three
// Horner stages each take a multiply state and an accumulate state on the one
// shared multiplier. A query outside the span is known at the end of the search
// and skips the Horner stages. An empty table skips the search. The input is
// stalled while an evaluation is in progress. The result waits in an output
// register, and a new item may be transferred while it does. The next
// evaluation cannot finish while that register is still waiting for its
// transfer, so it is held in its final state until the register is free.
`include "piecewise_cubic_evaluator_core_macros.svh"

module piecewise_cubic_evaluator_core #(
  parameter int unsigned MAX_SEGMENTS = 32,
  parameter int unsigned FRAC_BITS    = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pce_pkg::CfgW-1:0]          cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              operation_i,
  input  logic [pce_pkg::IdxW-1:0]          entry_index_i,
  input  logic [pce_pkg::DataW-1:0]         knot_time_i,
  input  logic signed [pce_pkg::DataW-1:0]  coef_cubic_i,
  input  logic signed [pce_pkg::DataW-1:0]  coef_square_i,
  input  logic signed [pce_pkg::DataW-1:0]  coef_linear_i,
  input  logic signed [pce_pkg::DataW-1:0]  coef_constant_i,
  input  logic [pce_pkg::DataW-1:0]         query_time_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [pce_pkg::DataW-1:0]  value_o,
  output logic [pce_pkg::IdxW-1:0]          segment_used_o,
  output logic                              out_of_range_o,
  output logic                              saturated_o
);

  localparam int unsigned W    = pce_pkg::DataW;
  localparam int unsigned AW   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned NW   = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned LimW = (NW > pce_pkg::CfgW) ? NW : pce_pkg::CfgW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_LOAD  = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_ACC   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  localparam logic [1:0] STG_SQUARE   = 2'd0;
  localparam logic [1:0] STG_LINEAR   = 2'd1;
  localparam logic [1:0] STG_CONSTANT = 2'd2;

  logic [2:0]               state_q, state_d;
  logic [pce_pkg::CfgW-1:0] siu_q;
  logic [NW-1:0]            n_q, n_d;
  logic [NW-1:0]            issue_q, issue_d;
  logic                     pend_q, pend_d;
  logic [AW-1:0]            cmp_idx_q, cmp_idx_d;
  logic [AW-1:0]            chosen_q, chosen_d;
  logic                     oor_q, oor_d;
  logic [W-1:0]             query_q, query_d;
  logic [W-1:0]             diff_q, diff_d;
  logic [1:0]               stage_q, stage_d;

  logic                     out_valid_q, out_valid_d;
  logic signed [W-1:0]      value_q, value_d;
  logic [pce_pkg::IdxW-1:0] seg_used_q, seg_used_d;
  logic                     out_oor_q, out_oor_d;
  logic                     out_sat_q, out_sat_d;

  logic                     in_xfer;
  logic [LimW-1:0]          siu_ext;
  logic [LimW-1:0]          max_ext;
  logic [LimW-1:0]          n_lim;
  logic                     mem_we;
  pce_pkg::seg_t            wdata;
  logic [AW-1:0]            raddr;
  pce_pkg::seg_t            rdata;
  logic                     issuing;
  logic                     knot_ok;
  logic                     is_first;
  logic                     is_last;
  logic                     oor_next;
  pce_pkg::mac_ctrl_t       mac_ctrl;
  logic signed [W-1:0]      coef_sel;
  logic signed [W-1:0]      acc;
  logic                     clip;
  logic                     out_free;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i & ~in_stall_o;
  assign out_free   = ~out_valid_q | ~out_stall_i;

  // A register value beyond the table size searches the whole table.
  assign siu_ext = LimW'(siu_q);
  assign max_ext = LimW'(MAX_SEGMENTS);
  assign n_lim   = (siu_ext > max_ext) ? max_ext : siu_ext;

  assign mem_we = in_xfer && (operation_i == pce_pkg::OP_WRITE) &&
                  (32'(entry_index_i) < 32'(MAX_SEGMENTS));
  assign wdata  = '{knot:     knot_time_i,
                    cubic:    coef_cubic_i,
                    square:   coef_square_i,
                    linear:   coef_linear_i,
                    constant: coef_constant_i};

  assign issuing = (state_q == S_SCAN) && (issue_q < n_q);
  assign raddr   = issuing ? issue_q[AW-1:0] : chosen_q;

  pce_seg_mem #(
    .DEPTH (MAX_SEGMENTS),
    .AW    (AW)
  ) u_seg_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (AW'(entry_index_i)),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Compare of the knot that arrived from the memory this cycle.
  assign knot_ok  = (rdata.knot <= query_q);
  assign is_first = (cmp_idx_q == '0);
  assign is_last  = ((NW'(cmp_idx_q) + NW'(1)) == n_q);
  assign oor_next = oor_q | (is_first & ~knot_ok) | (is_last & (query_q > rdata.knot));

  always_comb begin
    case (stage_q)
      STG_SQUARE:   coef_sel = rdata.square;
      STG_LINEAR:   coef_sel = rdata.linear;
      default:      coef_sel = rdata.constant;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    issue_d     = issue_q;
    pend_d      = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    chosen_d    = chosen_q;
    oor_d       = oor_q;
    query_d     = query_q;
    diff_d      = diff_q;
    stage_d     = stage_q;
    mac_ctrl    = '0;
    out_valid_d = out_valid_q & out_stall_i;
    value_d     = value_q;
    seg_used_d  = seg_used_q;
    out_oor_d   = out_oor_q;
    out_sat_d   = out_sat_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer && (operation_i == pce_pkg::OP_EVAL)) begin
          query_d  = query_time_i;
          n_d      = n_lim[NW-1:0];
          issue_d  = '0;
          chosen_d = '0;
          oor_d    = (n_lim == '0);
          state_d  = (n_lim == '0) ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (issuing) begin
          issue_d   = issue_q + NW'(1);
          pend_d    = 1'b1;
          cmp_idx_d = issue_q[AW-1:0];
        end
        if (pend_q) begin
          oor_d = oor_next;
          if (knot_ok) begin
            chosen_d = cmp_idx_q;
          end
          if (is_last) begin
            state_d = oor_next ? S_DONE : S_FETCH;
          end
        end
      end
      S_FETCH: begin
        state_d = S_LOAD;
      end
      S_LOAD: begin
        mac_ctrl.load = 1'b1;
        diff_d        = query_q - rdata.knot;
        stage_d       = STG_SQUARE;
        state_d       = S_MUL;
      end
      S_MUL: begin
        mac_ctrl.mul = 1'b1;
        state_d      = S_ACC;
      end
      S_ACC: begin
        mac_ctrl.acc = 1'b1;
        if (stage_q == STG_CONSTANT) begin
          state_d = S_DONE;
        end else begin
          stage_d = stage_q + 2'd1;
          state_d = S_MUL;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          value_d     = oor_q ? '0 : acc;
          seg_used_d  = oor_q ? '0 : pce_pkg::IdxW'(chosen_q);
          out_oor_d   = oor_q;
          out_sat_d   = ~oor_q & clip;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  pce_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .diff_i (diff_q),
    .init_i (rdata.cubic),
    .coef_i (coef_sel),
    .acc_o  (acc),
    .clip_o (clip)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      siu_q       <= '0;
      issue_q     <= '0;
      pend_q      <= 1'b0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      issue_q     <= issue_d;
      pend_q      <= pend_d;
      n_q         <= n_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        siu_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q  <= cmp_idx_d;
    chosen_q   <= chosen_d;
    oor_q      <= oor_d;
    query_q    <= query_d;
    diff_q     <= diff_d;
    stage_q    <= stage_d;
    value_q    <= value_d;
    seg_used_q <= seg_used_d;
    out_oor_q  <= out_oor_d;
    out_sat_q  <= out_sat_d;
  end

  assign out_valid_o    = out_valid_q;
  assign value_o        = value_q;
  assign segment_used_o = seg_used_q;
  assign out_of_range_o = out_oor_q;
  assign saturated_o    = out_sat_q;

  `PCE_ASSERT(a_eval_goes_busy, clk_i, rst_ni, in_valid_i && !in_stall_o && (operation_i == pce_pkg::OP_EVAL) |=> in_stall_o, "evaluate transfer did not start a search")
  `PCE_ASSERT(a_oor_result_zero, clk_i, rst_ni, out_valid_o && out_of_range_o |-> (value_o == '0) && !saturated_o && (segment_used_o == '0), "out-of-range result is not zero")
  `PCE_ASSERT(a_scan_bounded, clk_i, rst_ni, (state_q == S_SCAN) |-> (issue_q <= n_q), "knot search ran past the segments in use")
  `PCE_ASSERT_ALWAYS(a_no_out_in_reset, clk_i, !rst_ni |=> !out_valid_o, "result presented straight after reset")

endmodule
